/* rtl/bclsu_pkg.sv */
package bclsu_pkg;

	localparam int MemBytesDefault = 4096;

	localparam logic [31:0] ClassMask  = 32'hFFF0_00F0;
	localparam logic [31:0] ClassBchk  = 32'hE7F0_00F0;
	localparam logic [31:0] ClassLoad  = 32'hE7E0_00F0;
	localparam logic [31:0] ClassStore = 32'hE7D0_00F0;

	localparam logic [2:0] OpExec    = 3'd0;
	localparam logic [2:0] OpRegWr   = 3'd1;
	localparam logic [2:0] OpRegRd   = 3'd2;
	localparam logic [2:0] OpMemWr   = 3'd3;
	localparam logic [2:0] OpMemRd   = 3'd4;

	localparam logic [1:0] StOk      = 2'd0;
	localparam logic [1:0] StBounds  = 2'd1;
	localparam logic [1:0] StUnknown = 2'd2;
	localparam logic [1:0] StBadMode = 2'd3;

	localparam logic [3:0] ModeU8  = 4'd0;
	localparam logic [3:0] ModeS8  = 4'd1;
	localparam logic [3:0] ModeU16 = 4'd2;
	localparam logic [3:0] ModeS16 = 4'd3;
	localparam logic [3:0] ModeU32 = 4'd4;

	typedef enum logic [2:0] {
		K_NONE,    // result status only, no state change
		K_REGWR,
		K_REGRD,
		K_MEMWR,
		K_MEMRD,
		K_BCHK,
		K_LOAD,
		K_STORE
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [1:0]  status;
		logic [3:0]  ra;
		logic [3:0]  rb;
		logic [3:0]  rc;
		logic [3:0]  mode;
		logic [7:0]  imm;
		logic [11:0] haddr;
		logic [31:0] hdata;
	} cmd_t;

endpackage

/* rtl/bclsu_ram.sv */
module bclsu_ram #(
	parameter int Width = 8,
	parameter int Depth = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/bclsu_front.sv */
module bclsu_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        opcode,
	input  logic [31:0]       instr_word,
	input  logic [3:0]        reg_select,
	input  logic [11:0]       host_address,
	input  logic [31:0]       host_data,
	output logic              q_valid,
	input  logic              q_ready,
	output bclsu_pkg::cmd_t   q_cmd
);
	import bclsu_pkg::*;

	// two-entry queue
	cmd_t       buf_q [2];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;
	cmd_t       c;
	logic [15:0] p;
	logic [31:0] cls;
	logic       push, pop;

	always_comb begin
		p   = {instr_word[19:8], instr_word[3:0]};
		cls = instr_word & ClassMask;
		c = '0;
		c.kind   = K_NONE;
		c.status = StOk;
		c.ra     = reg_select;
		c.rb     = p[11:8];
		c.rc     = p[7:4];
		c.mode   = p[3:0];
		c.imm    = p[7:0];
		c.haddr  = host_address;
		c.hdata  = host_data;
		case (opcode)
			OpExec: begin
				c.ra = p[15:12];
				if (cls == ClassBchk) begin
					c.kind = K_BCHK;
				end else if (cls == ClassLoad) begin
					if (p[3:0] inside {ModeU8, ModeS8, ModeU16, ModeS16, ModeU32})
						c.kind = K_LOAD;
					else
						c.status = StBadMode;
				end else if (cls == ClassStore) begin
					if (p[3:0] inside {ModeU8, ModeU16, ModeU32})
						c.kind = K_STORE;
					else
						c.status = StBadMode;
				end else begin
					c.status = StUnknown;
				end
			end
			OpRegWr: c.kind = K_REGWR;
			OpRegRd: c.kind = K_REGRD;
			OpMemWr: c.kind = K_MEMWR;
			OpMemRd: c.kind = K_MEMRD;
			default: c.status = StUnknown;
		endcase
	end

	assign in_ready = cnt_q != 2'd2;
	assign q_valid  = cnt_q != 2'd0;
	assign q_cmd    = buf_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

/* rtl/bclsu_back.sv */
module bclsu_back #(
	parameter int MemBytes = bclsu_pkg::MemBytesDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  bclsu_pkg::cmd_t q_cmd,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [1:0]      status,
	output logic [31:0]     read_data,
	output logic            carry_out
);
	import bclsu_pkg::*;

	localparam int AW = $clog2(MemBytes);

	// sequencer: byte-serial memory access, up to four bytes
	logic [31:0] rf_q [16];
	logic        carry_q;
	logic        busy_q;
	cmd_t        cmd_q;
	logic [2:0]  nbytes_q;   // bytes in access
	logic [2:0]  idx_q;      // byte being issued
	logic        rd_pend_q;  // read data arrives this cycle
	logic [1:0]  rd_lane_q;
	logic [AW-1:0] base_q;
	logic [31:0] acc_q;
	logic [31:0] stv_q;

	logic        ov_q;
	logic [1:0]  ost_q;
	logic [31:0] odat_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;

	logic [31:0] addr_full;
	logic [AW-1:0] a_mod;
	logic [32:0] sum;
	logic        start, can_finish;
	logic [2:0]  nb;
	logic [31:0] acc_n, ld_val;

	// memory size is a power of two, so the address wraps by keeping the low bits
	assign addr_full = rf_q[q_cmd.rb] + rf_q[q_cmd.rc];
	assign a_mod     = addr_full[AW-1:0];

	assign out_valid = ov_q;
	assign status    = ost_q;
	assign read_data = odat_q;
	assign carry_out = carry_q;

	assign can_finish = !ov_q || out_ready;
	assign q_ready    = !busy_q && can_finish;
	assign start      = q_valid && q_ready;

	always_comb begin
		case (q_cmd.mode)
			ModeU8, ModeS8:   nb = 3'd1;
			ModeU16, ModeS16: nb = 3'd2;
			default:          nb = 3'd4;
		endcase
	end

	function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] b, logic [2:0] i);
		logic [AW:0] s;
		s = {1'b0, b} + (AW+1)'(i);
		if (s >= (AW+1)'(MemBytes)) s = s - (AW+1)'(MemBytes);
		return s[AW-1:0];
	endfunction

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wrap_add(base_q, idx_q);
		ram_wdata = stv_q[8*idx_q[1:0] +: 8];
		ram_raddr = wrap_add(base_q, idx_q);
		if (start && q_cmd.kind == K_MEMWR) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(q_cmd.haddr);
			ram_wdata = q_cmd.hdata[7:0];
		end else if (start && q_cmd.kind == K_MEMRD) begin
			ram_raddr = AW'(q_cmd.haddr);
		end else if (busy_q && cmd_q.kind == K_STORE && idx_q < nbytes_q) begin
			ram_we = 1'b1;
		end
	end

	bclsu_ram #(.Width(8), .Depth(MemBytes)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		acc_n = acc_q;
		if (rd_pend_q) acc_n[8*rd_lane_q +: 8] = ram_rdata;
		case (cmd_q.mode)
			ModeS8:  ld_val = {{24{acc_n[7]}}, acc_n[7:0]};
			ModeS16: ld_val = {{16{acc_n[15]}}, acc_n[15:0]};
			default: ld_val = acc_n;
		endcase
	end

	assign sum = {1'b0, rf_q[q_cmd.ra]} + {25'd0, q_cmd.imm};

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q    <= q_cmd;
			base_q   <= a_mod;
			nbytes_q <= nb;
			stv_q    <= rf_q[q_cmd.ra];
		end
		if (start && q_cmd.kind == K_MEMRD) begin
			rd_lane_q <= 2'd0;
		end else if (busy_q) begin
			rd_lane_q <= idx_q[1:0];
		end
		if (start) acc_q <= '0;
		else       acc_q <= acc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) rf_q[i] <= '0;
			carry_q   <= 1'b0;
			busy_q    <= 1'b0;
			idx_q     <= '0;
			rd_pend_q <= 1'b0;
			ov_q      <= 1'b0;
			ost_q     <= StOk;
			odat_q    <= '0;
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			rd_pend_q <= 1'b0;
			if (start) begin
				ost_q  <= q_cmd.status;
				odat_q <= '0;
				case (q_cmd.kind)
					K_REGWR: begin
						rf_q[q_cmd.ra] <= q_cmd.hdata;
						ov_q <= 1'b1;
					end
					K_REGRD: begin
						odat_q <= rf_q[q_cmd.ra];
						ov_q   <= 1'b1;
					end
					K_MEMWR: ov_q <= 1'b1;
					K_MEMRD: begin
						busy_q    <= 1'b1;
						rd_pend_q <= 1'b1;
						idx_q     <= 3'd4;
					end
					K_BCHK: begin
						if (sum[32] || sum[31:0] > rf_q[q_cmd.rb]) begin
							carry_q <= 1'b1;
							ost_q   <= StBounds;
							rf_q[15] <= rf_q[15] + 32'd4;
						end else begin
							carry_q <= 1'b0;
							if (q_cmd.ra == 4'd15) rf_q[15] <= sum[31:0] + 32'd4;
							else begin
								rf_q[q_cmd.ra] <= sum[31:0];
								rf_q[15]       <= rf_q[15] + 32'd4;
							end
						end
						ov_q <= 1'b1;
					end
					K_LOAD, K_STORE: begin
						busy_q <= 1'b1;
						idx_q  <= '0;
					end
					default: ov_q <= 1'b1;
				endcase
			end else if (busy_q) begin
				if (cmd_q.kind == K_MEMRD) begin
					if (can_finish) begin
						busy_q <= 1'b0;
						ov_q   <= 1'b1;
						odat_q <= {24'd0, acc_n[7:0]};
					end
				end else if (idx_q < nbytes_q) begin
					idx_q     <= idx_q + 3'd1;
					rd_pend_q <= cmd_q.kind == K_LOAD;
				end else if (can_finish && (cmd_q.kind == K_STORE || !rd_pend_q)) begin
					busy_q <= 1'b0;
					ov_q   <= 1'b1;
					if (cmd_q.kind == K_LOAD) begin
						odat_q <= ld_val;
						if (cmd_q.ra == 4'd15) rf_q[15] <= ld_val + 32'd4;
						else begin
							rf_q[cmd_q.ra] <= ld_val;
							rf_q[15]       <= rf_q[15] + 32'd4;
						end
					end else begin
						rf_q[15] <= rf_q[15] + 32'd4;
					end
				end
			end
		end
	end
endmodule

/* rtl/bounds_check_load_store_unit.sv */
// register and bounds-check items get their result registered when the back end takes them; a host
// memory read waits for the byte ram read data; a store or a load steps through its memory
// bytes one at a time through the byte ram, and a load then waits for the last read data
// throughput: one register or bounds-check item per cycle while the output is not stalled;
// the back end takes no new item during a host memory read, a store or a load until it is done
// arst_n clears registers, carry, queue and output valid; memory is not cleared
module bounds_check_load_store_unit #(
	parameter int MemBytes = bclsu_pkg::MemBytesDefault  // byte count, a power of two
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [87:0]  s_tdata,  // opcode, instr_word, reg_select, host_address, host_data
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [39:0]  m_tdata   // status, read_data, carry_out, zero pad
);
	import bclsu_pkg::*;

	logic  q_valid, q_ready;
	cmd_t  q_cmd;
	logic [1:0]  st;
	logic [31:0] rd;
	logic        co;

	// front: decode and classify, 2-entry queue towards the back
	bclsu_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.opcode       (s_tdata[2:0]),
		.instr_word   (s_tdata[34:3]),
		.reg_select   (s_tdata[38:35]),
		.host_address (s_tdata[50:39]),
		.host_data    (s_tdata[82:51]),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_cmd        (q_cmd)
	);

	// back: register file, carry, memory sequencing
	bclsu_back #(.MemBytes(MemBytes)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_cmd     (q_cmd),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (st),
		.read_data (rd),
		.carry_out (co)
	);

	assign m_tdata = {5'd0, co, rd, st};
endmodule

/* rtl/bclsu_checker.sv */
module bclsu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid)
		else $error("input item withdrawn while stalled");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output item dropped or changed while stalled");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:35] == 5'd0)
		else $error("output padding not zero");

	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == 2'd2 || m_tdata[1:0] == 2'd3) |->
		m_tdata[33:2] == 32'd0)
		else $error("faulting item returned data");

	a_bchk: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == 2'd1 |-> m_tdata[34])
		else $error("bounds failure without carry");
endmodule

bind bounds_check_load_store_unit bclsu_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* bench/bounds_check_load_store_unit_test.sv */
`timescale 1ns / 100ps

module bounds_check_load_store_unit_test;
	import bclsu_pkg::*;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] data;
		logic        carry;
	} result_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [87:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [39:0]  m_tdata;

	// shadow copy of the unit's architectural state
	logic [31:0] regs [16];
	logic        carry;
	logic [7:0]  mem [MemBytesDefault];
	bit          written [MemBytesDefault];

	result_t result_q [$];
	int      errors;
	int      sent;
	int      received;
	int      n_exec;
	int      n_host;

	bounds_check_load_store_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("status: fail");
		$finish;
	end

	function automatic int access_bytes(logic [3:0] mode);
		case (mode)
			ModeU8, ModeS8:   return 1;
			ModeU16, ModeS16: return 2;
			ModeU32:          return 4;
			default:          return 0;
		endcase
	endfunction

	// compute the result of one accepted item and advance the shadow state
	function automatic result_t run_item(logic [2:0] op, logic [31:0] word, logic [3:0] rsel,
	                                     logic [11:0] haddr, logic [31:0] hdata);
		result_t r;
		logic [15:0] p;
		logic [31:0] cls;
		logic [3:0] ra, rb, rc, mode;
		logic [31:0] addr, v;
		logic [32:0] sum;
		logic [11:0] idx;
		int n;
		r.status = StOk;
		r.data = '0;
		p = {word[19:8], word[3:0]};
		cls = word & ClassMask;
		ra = p[15:12];
		rb = p[11:8];
		rc = p[7:4];
		mode = p[3:0];
		addr = regs[rb] + regs[rc];
		case (op)
			OpExec: begin
				if (cls == ClassBchk) begin
					sum = {1'b0, regs[ra]} + {25'd0, p[7:0]};
					if (sum[32] || sum[31:0] > regs[rb]) begin
						carry = 1'b1;
						r.status = StBounds;
					end else begin
						carry = 1'b0;
						regs[ra] = sum[31:0];
					end
					regs[15] = regs[15] + 32'd4;
				end else if (cls == ClassLoad) begin
					n = access_bytes(mode);
					if (n == 0) begin
						r.status = StBadMode;
					end else begin
						v = '0;
						for (int i = 0; i < n; i++) begin
							idx = addr[11:0] + 12'(i);
							v[8*i +: 8] = mem[idx];
						end
						if (mode == ModeS8 && v[7])
							v[31:8] = '1;
						if (mode == ModeS16 && v[15])
							v[31:16] = '1;
						regs[ra] = v;
						r.data = v;
						regs[15] = regs[15] + 32'd4;
					end
				end else if (cls == ClassStore) begin
					if (mode != ModeU8 && mode != ModeU16 && mode != ModeU32) begin
						r.status = StBadMode;
					end else begin
						n = access_bytes(mode);
						v = regs[ra];
						for (int i = 0; i < n; i++) begin
							idx = addr[11:0] + 12'(i);
							mem[idx] = v[8*i +: 8];
							written[idx] = 1'b1;
						end
						regs[15] = regs[15] + 32'd4;
					end
				end else begin
					r.status = StUnknown;
				end
			end
			OpRegWr: regs[rsel] = hdata;
			OpRegRd: r.data = regs[rsel];
			OpMemWr: begin
				mem[haddr] = hdata[7:0];
				written[haddr] = 1'b1;
			end
			OpMemRd: r.data = {24'd0, mem[haddr]};
			default: r.status = StUnknown;
		endcase
		r.carry = carry;
		return r;
	endfunction

	// one item to the unit; called at a rising edge, returns at the accepting edge
	task automatic send_item(logic [2:0] op, logic [31:0] word, logic [3:0] rsel,
	                         logic [11:0] haddr, logic [31:0] hdata);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, hdata, haddr, rsel, word, op};
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		result_q.push_back(run_item(op, word, rsel, haddr, hdata));
		sent++;
		if (op == OpExec)
			n_exec++;
		else
			n_host++;
	endtask

	function automatic logic [31:0] encode(logic [31:0] cls, logic [3:0] a, logic [3:0] b,
	                                       logic [3:0] c, logic [3:0] d);
		return cls | {12'd0, a, b, c, 4'd0, d};
	endfunction

	task automatic host_reg_write(logic [3:0] r, logic [31:0] v);
		send_item(OpRegWr, $urandom, r, 12'($urandom), v);
	endtask

	// a load never touches a byte that was never written: fill the gaps by host writes
	task automatic load(logic [3:0] rd, logic [3:0] base, logic [3:0] off, logic [3:0] mode);
		logic [31:0] addr;
		logic [11:0] idx;
		addr = regs[base] + regs[off];
		for (int i = 0; i < access_bytes(mode); i++) begin
			idx = addr[11:0] + 12'(i);
			if (!written[idx])
				send_item(OpMemWr, $urandom, 4'($urandom), idx, $urandom);
		end
		send_item(OpExec, encode(ClassLoad, rd, base, off, mode), 4'($urandom),
		          12'($urandom), $urandom);
	endtask

	task automatic host_mem_read(logic [11:0] a);
		if (!written[a])
			send_item(OpMemWr, $urandom, 4'($urandom), a, $urandom);
		send_item(OpMemRd, $urandom, 4'($urandom), a, $urandom);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// result side: random stalls, each item compared with the oldest expectation
	initial begin
		result_t want;
		int gap;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(negedge clk); while (!m_tvalid);
			received++;
			if (result_q.size() == 0) begin
				$display("%0t: unexpected item status=%0d data=%h carry=%b", $time,
				         m_tdata[1:0], m_tdata[33:2], m_tdata[34]);
				errors++;
			end else begin
				want = result_q.pop_front();
				if (m_tdata[1:0] !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status,
					         m_tdata[1:0]);
					errors++;
				end
				if (m_tdata[33:2] !== want.data) begin
					$display("%0t: read_data expected %h actual %h", $time, want.data,
					         m_tdata[33:2]);
					errors++;
				end
				if (m_tdata[34] !== want.carry) begin
					$display("%0t: carry expected %b actual %b", $time, want.carry,
					         m_tdata[34]);
					errors++;
				end
			end
			@(posedge clk);
		end
	end

	// host paths: register extremes, memory ends, undefined opcodes
	task automatic test_host_access();
		host_reg_write(4'd0, 32'hFFFF_FFFF);
		host_reg_write(4'd15, 32'd0);
		send_item(OpRegRd, '0, 4'd0, '0, '0);
		send_item(OpMemWr, '0, '0, 12'hFFF, 32'hFFFF_FF5A);
		send_item(OpMemWr, '0, '0, 12'h000, 32'h0000_00A5);
		send_item(OpMemRd, '0, '0, 12'hFFF, '0);
		send_item(3'd5, '1, '1, '1, '1);
		send_item(3'd7, '0, '0, '0, '0);
	endtask

	// bounds check passing on the limit, failing just past it and on carry out
	task automatic test_bounds_check();
		host_reg_write(4'd1, 32'd10);
		host_reg_write(4'd2, 32'd265);
		send_item(OpExec, encode(ClassBchk, 4'd1, 4'd2, 4'hF, 4'hF), '0, '0, '0);
		send_item(OpExec, encode(ClassBchk, 4'd1, 4'd2, 4'd0, 4'd1), '0, '0, '0);
		send_item(OpExec, encode(ClassBchk, 4'd0, 4'd0, 4'd0, 4'd1), '0, '0, '0);
	endtask

	// every load mode, a word store, wrap past the end of memory, bad modes, an unknown word
	task automatic test_load_store();
		host_reg_write(4'd3, 32'hFFFF_FFFE);
		host_reg_write(4'd4, 32'h8081_F2F3);
		send_item(OpExec, encode(ClassStore, 4'd4, 4'd3, 4'd5, ModeU32), '0, '0, '0);
		for (int m = ModeU8; m <= ModeU32; m++)
			load(4'd6, 4'd3, 4'd5, 4'(m));
		send_item(OpExec, encode(ClassLoad, 4'd6, 4'd3, 4'd5, 4'hF), '0, '0, '0);
		send_item(OpExec, encode(ClassStore, 4'd6, 4'd3, 4'd5, ModeS8), '0, '0, '0);
		send_item(OpExec, 32'h1234_5678, '0, '0, '0);
	endtask

	task automatic test_random(int count);
		int r;
		logic [3:0] a, b, c;
		logic [31:0] v;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			a = 4'($urandom);
			b = 4'($urandom);
			c = 4'($urandom);
			if (k == count / 2)
				drain();
			if (r < 15) begin
				case ($urandom_range(0, 2))
					0: v = $urandom;
					1: v = $urandom_range(0, 600);
					default: v = 32'hFFFF_FFFF - $urandom_range(0, 300);
				endcase
				host_reg_write(a, v);
			end else if (r < 22)
				send_item(OpRegRd, $urandom, a, 12'($urandom), $urandom);
			else if (r < 30)
				send_item(OpMemWr, $urandom, a, 12'($urandom), $urandom);
			else if (r < 36)
				host_mem_read(12'($urandom));
			else if (r < 55)
				send_item(OpExec, encode(ClassBchk, a, b, c, 4'($urandom)), $urandom,
				          12'($urandom), $urandom);
			else if (r < 70)
				load(a, b, c, 4'($urandom_range(0, 4)));
			else if (r < 85)
				send_item(OpExec, encode(ClassStore, a, b, c, 4'(2 * $urandom_range(0, 2))),
				          $urandom, 12'($urandom), $urandom);
			else if (r < 90)
				send_item(OpExec, encode($urandom_range(0, 1) ? ClassLoad : ClassStore, a, b, c,
				          4'($urandom_range(5, 15))), $urandom, 12'($urandom), $urandom);
			else if (r < 95)
				// bit 4 clear keeps the word outside every known class
				send_item(OpExec, $urandom & 32'hFFFF_FFEF, $urandom, 12'($urandom),
				          $urandom);
			else
				send_item(3'($urandom_range(5, 7)), $urandom, a, 12'($urandom), $urandom);
		end
	endtask

	initial begin
		errors = 0;
		sent = 0;
		received = 0;
		n_exec = 0;
		n_host = 0;
		carry = 1'b0;
		for (int i = 0; i < 16; i++)
			regs[i] = '0;
		for (int i = 0; i < MemBytesDefault; i++) begin
			mem[i] = '0;
			written[i] = 1'b0;
		end
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_host_access();
		test_bounds_check();
		test_load_store();
		test_random(740);
		drain();
		$display("covered %0d items (%0d instruction words, %0d host accesses)", sent,
		         n_exec, n_host);
		$display("%0d results checked with random stalls on both sides", received);
		if (errors == 0 && result_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
